@@ rtl/core/ipb_pkg.sv @@
// ----------------------------------------------------------------------------
// ipb_pkg
// Shared types and constants of the indexed pixel palette blitter.
// ----------------------------------------------------------------------------
package ipb_pkg;

  localparam int FRAME_WIDTH_DEF   = 640;
  localparam int FRAME_HEIGHT_DEF  = 480;
  localparam int MAX_IMAGE_DIM_DEF = 1024;

  // Signed framebuffer coordinates: a 12-bit origin plus a column of up to
  // 12 bits always fits.
  localparam int COORD_W    = 14;
  localparam int ADDR_W     = 19;
  localparam int COLOR_W    = 24;
  localparam int ARGB_W     = 32;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 56;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_IMAGE   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_DEST_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH    = 3'd4;

  typedef struct packed {
    logic signed [11:0] dest_x;
    logic signed [11:0] dest_y;
    logic [10:0]        image_width;
    logic [10:0]        image_height;
    logic [3:0]         bit_depth;
  } cfg_t;

  // One pixel as it leaves the walker.
  typedef struct packed {
    logic                      emit;
    logic                      last_pix;
    logic                      done;
    logic signed [COORD_W-1:0] fx;
    logic signed [COORD_W-1:0] fy;
  } pix_t;

endpackage

@@ rtl/core/indexed_pixel_palette_blit.sv @@
// ----------------------------------------------------------------------------
// indexed_pixel_palette_blit
// Expands packed palette indices into framebuffer writes with ARGB colors.
// ----------------------------------------------------------------------------
// Channel   Direction  Moves
// s_*       in         palette write or one packed image byte
// m_*       out        framebuffer word address and opaque ARGB color
// cfg_*     in         register write: origin, image size, bit depth
//
// A palette write goes to the palette memory when it is accepted; an image
// byte yields one pixel per cycle while the output does not stall (8, 4, 2
// or 1 at depth 1, 2, 4, 8, fewer at the image end), set by the single
// palette read port. A result is held while the pixels after it in its byte
// are transparent or clipped. Reset clears position and origin and sets a
// 1x1 image at depth 8; palette contents are unknown until written. A
// stalled output backs up through the pixel pipeline to s_tready.
// ----------------------------------------------------------------------------
module indexed_pixel_palette_blit #(
  parameter int FRAME_WIDTH   = ipb_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT  = ipb_pkg::FRAME_HEIGHT_DEF,
  parameter int MAX_IMAGE_DIM = ipb_pkg::MAX_IMAGE_DIM_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  // palette_slot, red_in, green_in, blue_in, image_byte
  input  logic [ipb_pkg::S_TDATA_W-1:0]  s_tdata_i,
  // opcode
  input  logic                           s_tuser_i,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  // fb_address, argb_color, zero padding
  output logic [ipb_pkg::M_TDATA_W-1:0]  m_tdata_o,
  output logic                           m_tlast_o,
  // image_done
  output logic                           m_tuser_o,
  input  logic                           cfg_we_i,
  input  logic [ipb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ipb_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  ipb_pkg::cfg_t cfg_q, cfg_d;
  logic          pos_clr;
  logic          accept, start, pal_we;
  logic          ready, issue, emit_ready;
  logic [7:0]    idx;
  ipb_pkg::pix_t pix;
  logic [ipb_pkg::COLOR_W-1:0] rdata, color;
  logic [ipb_pkg::ADDR_W-1:0]  addr;

  always_comb begin
    cfg_d   = cfg_q;
    pos_clr = 1'b0;
    if (cfg_we_i) begin
      pos_clr = 1'b1;
      unique case (cfg_idx_i)
        ipb_pkg::REG_DEST_X:       cfg_d.dest_x       = cfg_data_i;
        ipb_pkg::REG_DEST_Y:       cfg_d.dest_y       = cfg_data_i;
        ipb_pkg::REG_IMAGE_WIDTH:  cfg_d.image_width  = cfg_data_i[10:0];
        ipb_pkg::REG_IMAGE_HEIGHT: cfg_d.image_height = cfg_data_i[10:0];
        ipb_pkg::REG_BIT_DEPTH:    cfg_d.bit_depth    = cfg_data_i[3:0];
        default:                   pos_clr            = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_x       <= '0;
      cfg_q.dest_y       <= '0;
      cfg_q.image_width  <= 11'd1;
      cfg_q.image_height <= 11'd1;
      cfg_q.bit_depth    <= 4'd8;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign s_tready_o = ready;
  assign accept     = s_tvalid_i && ready;
  assign start      = accept && (s_tuser_i == ipb_pkg::OP_IMAGE);
  assign pal_we     = accept && (s_tuser_i == ipb_pkg::OP_PALETTE);

  ipb_palette_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (s_tdata_i[7:0]),
    .wdata_i ({s_tdata_i[15:8], s_tdata_i[23:16], s_tdata_i[31:24]}),
    .re_i    (issue),
    .raddr_i (idx),
    .rdata_o (rdata)
  );

  ipb_walker #(
    .FRAME_WIDTH   (FRAME_WIDTH),
    .FRAME_HEIGHT  (FRAME_HEIGHT),
    .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pos_clr_i    (pos_clr),
    .start_i      (start),
    .byte_i       (s_tdata_i[39:32]),
    .next_ready_i (emit_ready),
    .ready_o      (ready),
    .issue_o      (issue),
    .idx_o        (idx),
    .pix_o        (pix)
  );

  ipb_emit #(
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_emit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .issue_i   (issue),
    .pix_i     (pix),
    .rdata_i   (rdata),
    .ready_o   (emit_ready),
    .m_ready_i (m_tready_i),
    .m_valid_o (m_tvalid_o),
    .addr_o    (addr),
    .color_o   (color),
    .last_o    (m_tlast_o),
    .done_o    (m_tuser_o)
  );

  assign m_tdata_o = {5'd0, ipb_pkg::ALPHA_OPAQUE, color, addr};

endmodule

@@ rtl/core/ipb_palette_ram.sv @@
// ----------------------------------------------------------------------------
// ipb_palette_ram
// 256 x 24 palette memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ipb_palette_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [7:0]                  waddr_i,
  input  logic [ipb_pkg::COLOR_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [7:0]                  raddr_i,
  output logic [ipb_pkg::COLOR_W-1:0] rdata_o
);

  logic [ipb_pkg::COLOR_W-1:0] mem_q [256];
  logic [ipb_pkg::COLOR_W-1:0] rdata_q;

  // A read in the same cycle as a write to that entry returns the old color.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/ipb_walker.sv @@
// ----------------------------------------------------------------------------
// ipb_walker
// Unpacks one image byte into pixels, one per cycle while the next stage is
// ready, and tracks the image column and row.
// ----------------------------------------------------------------------------
module ipb_walker #(
  parameter int FRAME_WIDTH   = ipb_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT  = ipb_pkg::FRAME_HEIGHT_DEF,
  parameter int MAX_IMAGE_DIM = ipb_pkg::MAX_IMAGE_DIM_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ipb_pkg::cfg_t cfg_i,
  input  logic          pos_clr_i,
  input  logic          start_i,
  input  logic [7:0]    byte_i,
  input  logic          next_ready_i,
  output logic          ready_o,
  output logic          issue_o,
  output logic [7:0]    idx_o,
  output ipb_pkg::pix_t pix_o
);

  localparam int DIM_W = $clog2(MAX_IMAGE_DIM + 1);
  localparam int COL_W = $clog2(MAX_IMAGE_DIM);
  localparam int CW    = ipb_pkg::COORD_W;

  logic             busy_q, busy_d;
  logic [7:0]       byte_q, byte_d;
  logic [3:0]       cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [COL_W-1:0] row_q, row_d;

  logic [DIM_W-1:0] width_c, height_c, remaining;
  logic [3:0]       depth_c, per_byte;
  logic             issue, wrap, done_c;
  logic [COL_W-1:0] col_nx, row_nx;
  logic [3:0]       cnt_start;
  logic [CW-1:0]    fx, fy;
  logic             visible;

  always_comb begin
    if (cfg_i.image_width == 11'd0) begin
      width_c = DIM_W'(1);
    end else if (int'(cfg_i.image_width) > MAX_IMAGE_DIM) begin
      width_c = DIM_W'(MAX_IMAGE_DIM);
    end else begin
      width_c = DIM_W'(cfg_i.image_width);
    end
    if (cfg_i.image_height == 11'd0) begin
      height_c = DIM_W'(1);
    end else if (int'(cfg_i.image_height) > MAX_IMAGE_DIM) begin
      height_c = DIM_W'(MAX_IMAGE_DIM);
    end else begin
      height_c = DIM_W'(cfg_i.image_height);
    end
  end

  always_comb begin
    unique case (cfg_i.bit_depth)
      4'd1: begin
        depth_c  = 4'd1;
        per_byte = 4'd8;
      end
      4'd2: begin
        depth_c  = 4'd2;
        per_byte = 4'd4;
      end
      4'd4: begin
        depth_c  = 4'd4;
        per_byte = 4'd2;
      end
      default: begin
        depth_c  = 4'd8;
        per_byte = 4'd1;
      end
    endcase
  end

  always_comb begin
    unique case (depth_c)
      4'd1:    idx_o = {7'd0, byte_q[7]};
      4'd2:    idx_o = {6'd0, byte_q[7:6]};
      4'd4:    idx_o = {4'd0, byte_q[7:4]};
      default: idx_o = byte_q;
    endcase
  end

  assign issue   = busy_q && next_ready_i;
  assign issue_o = issue;
  assign ready_o = !busy_q || (next_ready_i && (cnt_q == 4'd1));

  // Position after the pixel issued in this cycle.
  assign wrap = (DIM_W'(col_q) + DIM_W'(1)) == width_c;
  always_comb begin
    col_nx = col_q;
    row_nx = row_q;
    if (issue) begin
      if (wrap) begin
        col_nx = '0;
        if ((DIM_W'(row_q) + DIM_W'(1)) == height_c) begin
          row_nx = '0;
        end else begin
          row_nx = row_q + COL_W'(1);
        end
      end else begin
        col_nx = col_q + COL_W'(1);
      end
    end
  end

  // A byte ends the image when the pixels left in the last row fit in it.
  assign remaining = width_c - DIM_W'(col_nx);
  assign done_c    = ((DIM_W'(row_nx) + DIM_W'(1)) == height_c) &&
                     (remaining <= DIM_W'(per_byte));
  assign cnt_start = done_c ? remaining[3:0] : per_byte;

  assign fx = CW'(cfg_i.dest_x) + CW'(col_q);
  assign fy = CW'(cfg_i.dest_y) + CW'(row_q);
  assign visible = !fx[CW-1] && (fx[CW-2:0] < (CW-1)'(FRAME_WIDTH)) &&
                   !fy[CW-1] && (fy[CW-2:0] < (CW-1)'(FRAME_HEIGHT));

  always_comb begin
    pix_o.emit     = visible && (idx_o != 8'd0);
    pix_o.last_pix = cnt_q == 4'd1;
    pix_o.done     = done_q;
    pix_o.fx       = fx;
    pix_o.fy       = fy;
  end

  always_comb begin
    busy_d = busy_q;
    byte_d = byte_q;
    cnt_d  = cnt_q;
    done_d = done_q;
    if (issue) begin
      byte_d = byte_q << depth_c;
      cnt_d  = cnt_q - 4'd1;
      if (cnt_q == 4'd1) begin
        busy_d = 1'b0;
      end
    end
    if (start_i) begin
      busy_d = 1'b1;
      byte_d = byte_i;
      cnt_d  = cnt_start;
      done_d = done_c;
    end
    col_d = pos_clr_i ? '0 : col_nx;
    row_d = pos_clr_i ? '0 : row_nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

@@ rtl/core/ipb_emit.sv @@
// ----------------------------------------------------------------------------
// ipb_emit
// Joins each pixel with its palette color, forms the framebuffer address,
// and holds back one result so that the last one of a byte can be marked.
// ----------------------------------------------------------------------------
module ipb_emit #(
  parameter int FRAME_WIDTH = ipb_pkg::FRAME_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        issue_i,
  input  ipb_pkg::pix_t               pix_i,
  input  logic [ipb_pkg::COLOR_W-1:0] rdata_i,
  output logic                        ready_o,
  input  logic                        m_ready_i,
  output logic                        m_valid_o,
  output logic [ipb_pkg::ADDR_W-1:0]  addr_o,
  output logic [ipb_pkg::COLOR_W-1:0] color_o,
  output logic                        last_o,
  output logic                        done_o
);

  localparam int PROD_W = 26;
  localparam int CW     = ipb_pkg::COORD_W;

  logic                        s1_v_q;
  ipb_pkg::pix_t               s1_pix_q;
  logic                        s2_v_q, s2_emit_q, s2_lastpix_q, s2_done_q;
  logic [ipb_pkg::ADDR_W-1:0]  s2_addr_q, s2_addr_d;
  logic [ipb_pkg::COLOR_W-1:0] s2_color_q;
  logic                        pend_v_q, pend_final_q, pend_done_q;
  logic [ipb_pkg::ADDR_W-1:0]  pend_addr_q;
  logic [ipb_pkg::COLOR_W-1:0] pend_color_q;
  logic                        out_v_q, out_last_q, out_done_q;
  logic [ipb_pkg::ADDR_W-1:0]  out_addr_q;
  logic [ipb_pkg::COLOR_W-1:0] out_color_q;

  logic out_free, pend_move, pend_last, s2_take, s2_ready, s1_take;

  assign out_free  = !out_v_q || m_ready_i;
  // The held result leaves once it is known whether it closes its byte.
  assign pend_move = pend_v_q && out_free &&
                     (pend_final_q || (s2_v_q && (s2_emit_q || s2_lastpix_q)));
  assign pend_last = pend_final_q || !s2_emit_q;

  always_comb begin
    if (!s2_v_q) begin
      s2_take = 1'b0;
    end else if (s2_emit_q) begin
      s2_take = !pend_v_q || pend_move;
    end else if (s2_lastpix_q && pend_v_q && !pend_final_q) begin
      s2_take = pend_move;
    end else begin
      s2_take = 1'b1;
    end
  end

  assign s2_ready = !s2_v_q || s2_take;
  assign s1_take  = s1_v_q && s2_ready;
  assign ready_o  = !s1_v_q || s1_take;

  assign s2_addr_d = ipb_pkg::ADDR_W'(
      PROD_W'(s1_pix_q.fy[CW-3:0]) * PROD_W'(FRAME_WIDTH) +
      PROD_W'(s1_pix_q.fx[CW-3:0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      pend_v_q     <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      if (issue_i) begin
        s1_v_q <= 1'b1;
      end else if (s1_take) begin
        s1_v_q <= 1'b0;
      end
      if (s1_take) begin
        s2_v_q <= 1'b1;
      end else if (s2_take) begin
        s2_v_q <= 1'b0;
      end
      if (s2_take && s2_emit_q) begin
        pend_v_q <= 1'b1;
      end else if (pend_move) begin
        pend_v_q <= 1'b0;
      end
      if (pend_move) begin
        out_v_q <= 1'b1;
      end else if (m_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      s1_pix_q <= pix_i;
    end
    if (s1_take) begin
      s2_emit_q    <= s1_pix_q.emit;
      s2_lastpix_q <= s1_pix_q.last_pix;
      s2_done_q    <= s1_pix_q.done;
      s2_addr_q    <= s2_addr_d;
      s2_color_q   <= rdata_i;
    end
    if (s2_take && s2_emit_q) begin
      pend_final_q <= s2_lastpix_q;
      pend_done_q  <= s2_done_q;
      pend_addr_q  <= s2_addr_q;
      pend_color_q <= s2_color_q;
    end
    if (pend_move) begin
      out_last_q  <= pend_last;
      out_done_q  <= pend_done_q;
      out_addr_q  <= pend_addr_q;
      out_color_q <= pend_color_q;
    end
  end

  assign m_valid_o = out_v_q;
  assign addr_o    = out_addr_q;
  assign color_o   = out_color_q;
  assign last_o    = out_last_q;
  assign done_o    = out_done_q;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed pixel palette blitter. A short table of
// directed transactions covers the register extremes, transparency, clipping
// at every frame edge and an image that ends inside a byte. Random phases
// follow, each with fresh register settings. A predictor expands every
// accepted image byte into the framebuffer writes it should cause, and the
// output monitor compares each write with the oldest one still due.
// ----------------------------------------------------------------------------
module tb;
  import ipb_pkg::*;

  localparam int FB_W         = 640;
  localparam int FB_H         = 480;
  localparam int DIM_MAX      = 1024;
  localparam int DRAIN_CYCLES = 32;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 25;
  localparam int DIR_ROWS     = 51;

  // First register index past the end of the map; writes to it are dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ARGB_W-1:0] argb;
    logic              last;
    logic              done;
  } fb_write_t;

  localparam fb_write_t NO_WRITE = '0;

  typedef enum logic [1:0] {ROW_CFG, ROW_PAL, ROW_PIX} row_kind_e;

  // sel is the palette slot or register index, val the RGB color or register
  // data, pix the packed image byte. A typed row expects exactly one write.
  typedef struct {
    row_kind_e kind;
    logic [7:0]  sel;
    logic [23:0] val;
    logic [7:0]  pix;
    bit          typed;
    fb_write_t   exp;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_tvalid_i;
  logic                  s_tready_o;
  logic [S_TDATA_W-1:0]  s_tdata_i;
  logic                  s_tuser_i;
  logic                  m_tvalid_o;
  logic                  m_tready_i;
  logic [M_TDATA_W-1:0]  m_tdata_o;
  logic                  m_tlast_o;
  logic                  m_tuser_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  indexed_pixel_palette_blit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .m_tuser_o  (m_tuser_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Predictor state.
  logic [COLOR_W-1:0] pal_mem [256];
  bit                 pal_written [256];
  logic signed [11:0] blit_x0;
  logic signed [11:0] blit_y0;
  logic [10:0]        img_w;
  logic [10:0]        img_h;
  logic [3:0]         img_bpp;
  int                 pix_col;
  int                 pix_row;

  fb_write_t fb_writes_due [$];
  int        err_count;
  int        burst_left;
  bit        sent_since_cfg;

  row_t dir_tab [DIR_ROWS];

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    err_count++;
  endtask

  function automatic int eff_bpp();
    if (img_bpp == 4'd1 || img_bpp == 4'd2 || img_bpp == 4'd4) return int'(img_bpp);
    return 8;
  endfunction

  function automatic int clamp_dim(input logic [10:0] v);
    if (v == 0) return 1;
    if (int'(v) > DIM_MAX) return DIM_MAX;
    return int'(v);
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_DEST_X:       blit_x0 = d;
      REG_DEST_Y:       blit_y0 = d;
      REG_IMAGE_WIDTH:  img_w   = d[10:0];
      REG_IMAGE_HEIGHT: img_h   = d[10:0];
      REG_BIT_DEPTH:    img_bpp = d[3:0];
      default:          return;
    endcase
    pix_col = 0;
    pix_row = 0;
  endfunction

  // Walks the pixels of one image byte and, when keep is set, queues the
  // framebuffer writes they cause.
  function automatic void expand_byte(input logic [7:0] b, input bit keep);
    int        bpp, per, w, h, ox, oy, fx, fy, idx;
    bit        done;
    fb_write_t run [$];
    fb_write_t wr;
    bpp  = eff_bpp();
    per  = 8 / bpp;
    w    = clamp_dim(img_w);
    h    = clamp_dim(img_h);
    ox   = blit_x0;
    oy   = blit_y0;
    done = 1'b0;
    if (pix_col >= w) pix_col = 0;
    if (pix_row >= h) pix_row = 0;
    for (int k = 0; k < per; k++) begin
      idx = (int'(b) >> (8 - bpp * (k + 1))) & ((1 << bpp) - 1);
      fx  = ox + pix_col;
      fy  = oy + pix_row;
      if (idx != 0 && fx >= 0 && fx < FB_W && fy >= 0 && fy < FB_H) begin
        wr.addr = ADDR_W'(fy * FB_W + fx);
        wr.argb = {ALPHA_OPAQUE, pal_mem[idx]};
        wr.last = 1'b0;
        wr.done = 1'b0;
        run.push_back(wr);
      end
      pix_col++;
      if (pix_col >= w) begin
        pix_col = 0;
        pix_row++;
        if (pix_row >= h) begin
          pix_row = 0;
          done    = 1'b1;
          break;
        end
      end
    end
    if (run.size() > 0) begin
      run[run.size()-1].last = 1'b1;
      foreach (run[i]) begin
        run[i].done = done;
        if (keep) fb_writes_due.push_back(run[i]);
      end
    end
  endfunction

  // Replaces every nonzero index that points at a never-written palette slot
  // with a written one, so that no undefined entry is ever looked up.
  function automatic logic [7:0] legal_byte(input logic [7:0] b);
    int bpp, per, mask, shift, idx, start, cand;
    bpp  = eff_bpp();
    per  = 8 / bpp;
    mask = (1 << bpp) - 1;
    for (int k = 0; k < per; k++) begin
      shift = 8 - bpp * (k + 1);
      idx   = (int'(b) >> shift) & mask;
      if (idx != 0 && !pal_written[idx]) begin
        start = $urandom_range(1, mask);
        for (int j = 0; j < mask; j++) begin
          cand = ((start - 1 + j) % mask) + 1;
          if (pal_written[cand]) break;
        end
        b = (b & ~8'(mask << shift)) | 8'(cand << shift);
      end
    end
    return b;
  endfunction

  task automatic await_drain();
    s_tvalid_i <= 1'b0;
    while (fb_writes_due.size() != 0) @(posedge clk_i);
  endtask

  // Registers change only while the block is idle. Bytes that cause no
  // write may still be in flight, hence the extra cycles after the drain.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
    if (sent_since_cfg) begin
      await_drain();
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      sent_since_cfg = 1'b0;
    end
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    apply_reg(idx, d);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(input logic op, input logic [S_TDATA_W-1:0] d,
                           input bit keep);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= d;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    sent_since_cfg = 1'b1;
    if (op == OP_PALETTE) begin
      pal_mem[d[7:0]]     = {d[15:8], d[23:16], d[31:24]};
      pal_written[d[7:0]] = 1'b1;
    end else begin
      expand_byte(d[39:32], keep);
    end
  endtask

  // Receiver: ready pattern changes mode whenever its random run, counted in rx_left, ends.
  int rx_mode;
  int rx_left;
  int rx_tick;

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 96);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0:       m_tready_i <= 1'b1;
      1:       m_tready_i <= ($urandom_range(0, 3) != 0);
      2:       m_tready_i <= ($urandom_range(0, 3) == 0);
      default: m_tready_i <= (rx_tick % 5 == 0);
    endcase
  end

  fb_write_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (fb_writes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected write to %0d", m_tdata_o[ADDR_W-1:0]));
      end else begin
        want = fb_writes_due.pop_front();
        if (m_tdata_o[ADDR_W-1:0] != want.addr)
          report_mismatch($sformatf("address %0d, want %0d",
                                    m_tdata_o[ADDR_W-1:0], want.addr));
        if (m_tdata_o[ADDR_W +: ARGB_W] != want.argb)
          report_mismatch($sformatf("color %h, want %h at %0d",
                                    m_tdata_o[ADDR_W +: ARGB_W], want.argb, want.addr));
        if (m_tlast_o != want.last)
          report_mismatch($sformatf("tlast %b, want %b at %0d",
                                    m_tlast_o, want.last, want.addr));
        if (m_tuser_o != want.done)
          report_mismatch($sformatf("image done %b, want %b at %0d",
                                    m_tuser_o, want.done, want.addr));
      end
    end
  end

  initial begin
    logic [S_TDATA_W-1:0]  d;
    logic [CFG_DATA_W-1:0] v;
    fb_write_t             typed_exp;

    rst_ni         = 1'b0;
    s_tvalid_i     = 1'b0;
    s_tdata_i      = '0;
    s_tuser_i      = OP_PALETTE;
    m_tready_i     = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_DEST_X;
    cfg_data_i     = '0;
    err_count      = 0;
    burst_left     = 0;
    sent_since_cfg = 1'b0;
    rx_left        = 0;
    rx_tick        = 0;
    blit_x0        = '0;
    blit_y0        = '0;
    img_w          = 11'd1;
    img_h          = 11'd1;
    img_bpp        = 4'd8;
    pix_col        = 0;
    pix_row        = 0;
    foreach (pal_mem[i]) begin
      pal_mem[i]     = '0;
      pal_written[i] = 1'b0;
    end

    dir_tab = '{
      '{ROW_PAL, 8'd1,             24'h123456, 8'h00, 1'b0, NO_WRITE},
      // Reset settings: a 1x1 image at the origin, 8 bits per pixel.
      '{ROW_PIX, 8'd0,             24'h0,      8'h01, 1'b1,
        '{19'd0, 32'hFF123456, 1'b1, 1'b1}},
      '{ROW_PIX, 8'd0,             24'h0,      8'h00, 1'b0, NO_WRITE},
      '{ROW_PAL, 8'd0,             24'hAABBCC, 8'h00, 1'b0, NO_WRITE},
      '{ROW_PAL, 8'd255,           24'hFFFFFF, 8'h00, 1'b0, NO_WRITE},
      '{ROW_PAL, 8'd2,             24'h00FF00, 8'h00, 1'b0, NO_WRITE},
      '{ROW_PAL, 8'd3,             24'hFF0000, 8'h00, 1'b0, NO_WRITE},
      '{ROW_PAL, 8'd15,            24'h0000FF, 8'h00, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_DEST_X,       24'd639,    8'h00, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_DEST_Y,       24'd479,    8'h00, 1'b0, NO_WRITE},
      // Bottom right corner of the frame.
      '{ROW_PIX, 8'd0,             24'h0,      8'hFF, 1'b1,
        '{19'd307199, 32'hFFFFFFFF, 1'b1, 1'b1}},
      '{ROW_CFG, REG_DEST_X,       24'h800,    8'h00, 1'b0, NO_WRITE},
      '{ROW_PIX, 8'd0,             24'h0,      8'hFF, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_DEST_X,       24'h7FF,    8'h00, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_DEST_Y,       24'h800,    8'h00, 1'b0, NO_WRITE},
      '{ROW_PIX, 8'd0,             24'h0,      8'h01, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_DEST_Y,       24'h7FF,    8'h00, 1'b0, NO_WRITE},
      '{ROW_PIX, 8'd0,             24'h0,      8'h01, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_DEST_X,       24'd0,      8'h00, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_DEST_Y,       24'd0,      8'h00, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_IMAGE_WIDTH,  24'd16,     8'h00, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_IMAGE_HEIGHT, 24'd2,      8'h00, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_BIT_DEPTH,    24'd1,      8'h00, 1'b0, NO_WRITE},
      '{ROW_PIX, 8'd0,             24'h0,      8'hA5, 1'b0, NO_WRITE},
      '{ROW_PIX, 8'd0,             24'h0,      8'hFF, 1'b0, NO_WRITE},
      // A write past the register map must leave the position alone.
      '{ROW_CFG, REG_UNUSED,       24'hFFF,    8'h00, 1'b0, NO_WRITE},
      '{ROW_PIX, 8'd0,             24'h0,      8'h81, 1'b0, NO_WRITE},
      '{ROW_PIX, 8'd0,             24'h0,      8'h7E, 1'b0, NO_WRITE},
      // A three pixel image ends inside the byte.
      '{ROW_CFG, REG_IMAGE_WIDTH,  24'd3,      8'h00, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_IMAGE_HEIGHT, 24'd1,      8'h00, 1'b0, NO_WRITE},
      '{ROW_PIX, 8'd0,             24'h0,      8'hFF, 1'b0, NO_WRITE},
      // Zero sizes count as one.
      '{ROW_CFG, REG_BIT_DEPTH,    24'd2,      8'h00, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_IMAGE_WIDTH,  24'd0,      8'h00, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_IMAGE_HEIGHT, 24'd0,      8'h00, 1'b0, NO_WRITE},
      '{ROW_PIX, 8'd0,             24'h0,      8'hE4, 1'b0, NO_WRITE},
      // Oversized image running off the right edge.
      '{ROW_CFG, REG_BIT_DEPTH,    24'd4,      8'h00, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_IMAGE_WIDTH,  24'h7FF,    8'h00, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_IMAGE_HEIGHT, 24'd1024,   8'h00, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_DEST_X,       24'd600,    8'h00, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_DEST_Y,       24'd470,    8'h00, 1'b0, NO_WRITE},
      '{ROW_PIX, 8'd0,             24'h0,      8'hF1, 1'b0, NO_WRITE},
      '{ROW_PIX, 8'd0,             24'h0,      8'h2F, 1'b0, NO_WRITE},
      // Unsupported depths fall back to 8; bit 11 of the width is dropped.
      '{ROW_CFG, REG_BIT_DEPTH,    24'd3,      8'h00, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_IMAGE_WIDTH,  24'h805,    8'h00, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_IMAGE_HEIGHT, 24'd1,      8'h00, 1'b0, NO_WRITE},
      '{ROW_PIX, 8'd0,             24'h0,      8'hFF, 1'b0, NO_WRITE},
      '{ROW_PIX, 8'd0,             24'h0,      8'h02, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_BIT_DEPTH,    24'hFF0,    8'h00, 1'b0, NO_WRITE},
      '{ROW_PIX, 8'd0,             24'h0,      8'h03, 1'b0, NO_WRITE},
      '{ROW_PIX, 8'd0,             24'h0,      8'h0F, 1'b0, NO_WRITE},
      '{ROW_CFG, REG_BIT_DEPTH,    24'd8,      8'h00, 1'b0, NO_WRITE}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        ROW_CFG: write_reg(dir_tab[i].sel[CFG_IDX_W-1:0], dir_tab[i].val[11:0]);
        ROW_PAL: send_item(OP_PALETTE, {8'h00, dir_tab[i].val[7:0], dir_tab[i].val[15:8],
                                        dir_tab[i].val[23:16], dir_tab[i].sel}, 1'b1);
        default: begin
          send_item(OP_IMAGE, {dir_tab[i].pix, 32'h0}, !dir_tab[i].typed);
          if (dir_tab[i].typed) begin
            typed_exp = dir_tab[i].exp;
            fb_writes_due.push_back(typed_exp);
          end
        end
      endcase
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if ($urandom_range(0, 3) == 0)
        write_reg(3'(REG_BIT_DEPTH + 1 + $urandom_range(0, 2)), 12'($urandom));

      case ($urandom_range(0, 7))
        0:       v = 12'($urandom);
        1:       v = ($urandom_range(0, 1) != 0) ? 12'h800 : 12'h7FF;
        default: v = 12'($urandom_range(0, 680) - 20);
      endcase
      write_reg(REG_DEST_X, v);

      case ($urandom_range(0, 7))
        0:       v = 12'($urandom);
        1:       v = ($urandom_range(0, 1) != 0) ? 12'h800 : 12'h7FF;
        default: v = 12'($urandom_range(0, 500) - 10);
      endcase
      write_reg(REG_DEST_Y, v);

      // Mostly small images so that many of them complete.
      case ($urandom_range(0, 7))
        0:       v = 12'($urandom);
        1:       v = 12'd0;
        2:       v = 12'd1024;
        default: v = 12'($urandom_range(1, 20));
      endcase
      write_reg(REG_IMAGE_WIDTH, v);

      case ($urandom_range(0, 7))
        0:       v = 12'($urandom);
        1:       v = 12'd0;
        default: v = 12'($urandom_range(1, 4));
      endcase
      write_reg(REG_IMAGE_HEIGHT, v);

      if ($urandom_range(0, 4) == 0) v = 12'($urandom);
      else                           v = 12'(1 << $urandom_range(0, 3));
      write_reg(REG_BIT_DEPTH, v);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        d[31:0] = $urandom;
        if ($urandom_range(0, 3) == 0) begin
          d[39:32] = 8'($urandom);
          send_item(OP_PALETTE, d, 1'b1);
        end else begin
          d[39:32] = legal_byte(8'($urandom));
          send_item(OP_IMAGE, d, 1'b1);
        end
        // Hold the source once mid-phase until every write has come out.
        if (ph == 3 && n == PHASE_ITEMS / 2) await_drain();
      end
    end

    await_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
